// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. All of them sample on clk and are
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bpss_pkg.sv =====
`timescale 1ns / 1ps
package bpss_pkg;

  localparam int CFG_W     = 16;
  localparam int TIMER_W   = 16;
  localparam int LEVEL_W   = 4;
  localparam int POWER_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int SAT_IN_W  = CFG_W + 2;
  localparam int EXT_W     = (TIMER_W > SAT_IN_W) ? TIMER_W : SAT_IN_W;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [TIMER_W-1:0] TIMER_ONE = TIMER_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_WORD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd5;

  // Scheduler phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_SLOT  = 2'd1;
  localparam logic [1:0] PH_MAJOR = 2'd2;

  localparam logic [1:0] SLOT_LAST = 2'd3;
  localparam logic [CFG_W-1:0] MIN_CYCLE = CFG_W'(2);

  typedef struct packed {
    logic [CFG_W-1:0]   level_word;
    logic [LEVEL_W-1:0] receive_level;
    logic [CFG_W-1:0]   slot_period;
    logic [CFG_W-1:0]   cycle_period;
    logic [CFG_W-1:0]   window_length;
    logic               enable;
  } bpss_cfg_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic [1:0]         slot_idx;
    logic [TIMER_W-1:0] wait_cnt;
    logic [TIMER_W-1:0] win_cnt;
    logic               win_open;
  } bpss_state_t;

  typedef struct packed {
    logic               beacon;
    logic [LEVEL_W-1:0] beacon_level;
    logic [POWER_W-1:0] power_code;
    logic               receive_flag;
    logic               receiver_on;
    logic               halted;
  } bpss_result_t;

  // Clamp a loaded count to what the timers can hold.
  function automatic logic [TIMER_W-1:0] sat_load(input logic [SAT_IN_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e > EXT_W'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return e[TIMER_W-1:0];
  endfunction

  // Logical level to transmitter power setting.
  function automatic logic [POWER_W-1:0] power_map(input logic [LEVEL_W-1:0] lev);
    logic [POWER_W-1:0] p;
    case (lev)
      4'd0, 4'd1: p = 8'h01;
      4'd7:       p = 8'h0A;
      4'd8:       p = 8'h0F;
      4'd9:       p = 8'h60;
      4'd10:      p = 8'h70;
      4'd11:      p = 8'h80;
      4'd12:      p = 8'h90;
      4'd13:      p = 8'hC0;
      4'd14:      p = 8'hE0;
      4'd15:      p = 8'hFF;
      default:    p = POWER_W'(lev);
    endcase
    return p;
  endfunction

endpackage

// ===== src/bpss_in_if.sv =====
`timescale 1ns / 1ps
interface bpss_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// ===== src/bpss_out_if.sv =====
`timescale 1ns / 1ps
interface bpss_out_if
  import bpss_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               beacon;
  logic [LEVEL_W-1:0] beacon_level;
  logic [POWER_W-1:0] power_code;
  logic               receive_flag;
  logic               receiver_on;
  logic               halted;

  modport source (output valid, output beacon, output beacon_level, output power_code,
                  output receive_flag, output receiver_on, output halted, input ready);
  modport sink   (input valid, input beacon, input beacon_level, input power_code,
                  input receive_flag, input receiver_on, input halted, output ready);
endinterface

// ===== src/beacon_power_sweep_scheduler_core.sv =====
`timescale 1ns / 1ps
// Channel   Role    Payload                                                  Handshake
// in_ch     sink    tick                                                     valid/ready
// out_ch    source  beacon, beacon_level, power_code, receive_flag,          valid/ready
//                   receiver_on, halted
// cfg_*     write   cfg_idx selects the register, cfg_wdata carries it       cfg_we
//
// One transaction in, one result out; a new transaction is taken every cycle unless the result side stalls.
// Two register stages: an accepted transaction is held in the input register, stepped into the result
// register and presented from there.
// The step logic between those two registers is combinational.
// Reset (rst_n low, synchronous) clears the configuration, the scheduler state and both valids.
// A stalled result holds; the input register keeps taking one more transaction behind it.
`include "assert_macros.svh"
module beacon_power_sweep_scheduler_core
  import bpss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  bpss_in_if.sink              in_ch,
  bpss_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  bpss_cfg_t    cfg;
  bpss_state_t  state_r;
  bpss_state_t  state_nxt;
  bpss_result_t res;
  bpss_result_t res_r;
  logic         s1_valid_r;
  logic         s1_valid_nxt;
  logic         s1_tick_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         in_fire;
  logic         advance;
  logic         step_fire;

  bpss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpss_step u_step (
    .cfg    (cfg),
    .st     (state_r),
    .tick   (s1_tick_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign step_fire    = s1_valid_r && advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: PH_START, slot_idx: '0, wait_cnt: '0, win_cnt: '0,
                       win_open: 1'b0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tick_r <= in_ch.tick;
    end
    if (step_fire) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.beacon       = res_r.beacon;
  assign out_ch.beacon_level = res_r.beacon_level;
  assign out_ch.power_code   = res_r.power_code;
  assign out_ch.receive_flag = res_r.receive_flag;
  assign out_ch.receiver_on  = res_r.receiver_on;
  assign out_ch.halted       = res_r.halted;

  `BPSS_ASSERT_SAME(a_quiet_without_beacon, out_valid_r && !res_r.beacon, (res_r.beacon_level == '0) && (res_r.power_code == '0) && !res_r.receive_flag, "fields set on a result without a beacon")
  `BPSS_ASSERT_SAME(a_flag_opens_window, out_valid_r && res_r.receive_flag, res_r.receiver_on && res_r.beacon, "receive flag without an open window")
  `BPSS_ASSERT_SAME(a_halt_no_beacon, out_valid_r && res_r.halted, !res_r.beacon, "beacon sent on a halted tick")
  `BPSS_ASSERT_NEXT(a_stalled_item_kept, s1_valid_r && !advance, s1_valid_r, "pending transaction lost while stalled")

endmodule

// ===== src/bpss_cfg_regs.sv =====
`timescale 1ns / 1ps
module bpss_cfg_regs
  import bpss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output bpss_cfg_t            cfg
);

  bpss_cfg_t cfg_r;
  bpss_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_LEVEL_WORD:    cfg_nxt.level_word    = cfg_wdata;
        CFG_RECEIVE_LEVEL: cfg_nxt.receive_level = cfg_wdata[LEVEL_W-1:0];
        CFG_SLOT_PERIOD:   cfg_nxt.slot_period   = cfg_wdata;
        CFG_CYCLE_PERIOD:  cfg_nxt.cycle_period  = cfg_wdata;
        CFG_WINDOW_LENGTH: cfg_nxt.window_length = cfg_wdata;
        CFG_ENABLE:        cfg_nxt.enable        = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/bpss_step.sv =====
`timescale 1ns / 1ps
module bpss_step
  import bpss_pkg::*;
(
  input  bpss_cfg_t    cfg,
  input  bpss_state_t  st,
  input  logic         tick,
  output bpss_state_t  st_nxt,
  output bpss_result_t res
);

  logic [SAT_IN_W-1:0] four_slots;
  logic [SAT_IN_W-1:0] cycle_ext;

  assign four_slots = {2'b00, cfg.slot_period} << 2;
  assign cycle_ext  = SAT_IN_W'(cfg.cycle_period);

  always_comb begin
    logic               do_start;
    logic               do_slot;
    logic [1:0]         slot_sel;
    logic [LEVEL_W-1:0] lev;

    st_nxt   = st;
    res      = '0;
    do_start = 1'b0;
    do_slot  = 1'b0;
    slot_sel = st.slot_idx;
    lev      = '0;

    if (tick) begin
      // An open window counts down before any new beacon can reopen it.
      if (st.win_open) begin
        if (st.win_cnt <= TIMER_ONE) begin
          st_nxt.win_open = 1'b0;
          st_nxt.win_cnt  = '0;
        end else begin
          st_nxt.win_cnt = st.win_cnt - TIMER_ONE;
        end
      end

      case (st.phase)
        PH_SLOT: begin
          if (st.wait_cnt > TIMER_ONE) begin
            st_nxt.wait_cnt = st.wait_cnt - TIMER_ONE;
          end else if (st.slot_idx == SLOT_LAST) begin
            st_nxt.slot_idx = '0;
            if (cycle_ext > four_slots) begin
              st_nxt.wait_cnt = sat_load(cycle_ext - four_slots);
              st_nxt.phase    = PH_MAJOR;
            end else begin
              do_start = 1'b1;
            end
          end else begin
            st_nxt.slot_idx = st.slot_idx + 2'd1;
            slot_sel        = st.slot_idx + 2'd1;
            do_slot         = 1'b1;
          end
        end
        PH_MAJOR: begin
          if (st.wait_cnt > TIMER_ONE) begin
            st_nxt.wait_cnt = st.wait_cnt - TIMER_ONE;
          end else begin
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        if (!cfg.enable || (cfg.cycle_period < MIN_CYCLE)) begin
          res.halted   = 1'b1;
          st_nxt.phase = PH_START;
        end else begin
          st_nxt.slot_idx = '0;
          slot_sel        = '0;
          do_slot         = 1'b1;
        end
      end

      if (do_slot) begin
        lev = cfg.level_word[{slot_sel, 2'b00} +: LEVEL_W];
        if (lev != '0) begin
          res.beacon       = 1'b1;
          res.beacon_level = lev;
          res.power_code   = power_map(lev);
          if (lev == cfg.receive_level) begin
            res.receive_flag = 1'b1;
            if (!st_nxt.win_open) begin
              st_nxt.win_open = 1'b1;
              st_nxt.win_cnt  = sat_load(SAT_IN_W'(cfg.window_length));
            end
          end
        end
        st_nxt.wait_cnt = sat_load(SAT_IN_W'(cfg.slot_period));
        st_nxt.phase    = PH_SLOT;
      end
    end

    res.receiver_on = st_nxt.win_open;
  end

endmodule

// ===== sim/beacon_power_sweep_scheduler_core_tb.sv =====
`timescale 1ns / 1ps
module beacon_power_sweep_scheduler_core_tb;
  import bpss_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int RANDOM_ITEMS = 1950;

  localparam logic [POWER_W-1:0] TX_POWER [16] = '{
    8'h01, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h0A,
    8'h0F, 8'h60, 8'h70, 8'h80, 8'h90, 8'hC0, 8'hE0, 8'hFF
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  bpss_in_if  in_ch ();
  bpss_out_if out_ch ();

  beacon_power_sweep_scheduler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the scheduler registers and its configuration.
  logic [CFG_W-1:0]   sch_level_word = '0;
  logic [LEVEL_W-1:0] sch_rx_level   = '0;
  logic [CFG_W-1:0]   sch_slot_per   = '0;
  logic [CFG_W-1:0]   sch_cycle_per  = '0;
  logic [CFG_W-1:0]   sch_win_len    = '0;
  logic               sch_enable     = 1'b0;
  logic [1:0]         sch_phase      = PH_START;
  logic [1:0]         sch_slot       = '0;
  logic [TIMER_W-1:0] sch_wait       = '0;
  logic [TIMER_W-1:0] sch_win_cnt    = '0;
  logic               sch_win_open   = 1'b0;

  bpss_result_t pending_results [$];

  bit idle_on;
  int err_count;
  int cycle_count;
  int ticks_sent;
  int settings_loaded;
  int n_beacons;
  int n_flagged;
  int n_halted;

  function automatic logic [TIMER_W-1:0] clamp_timer(input longint unsigned v);
    return (v > longint'(TIMER_MAX)) ? TIMER_MAX : v[TIMER_W-1:0];
  endfunction

  function automatic void fire_slot(inout bpss_result_t r);
    logic [LEVEL_W-1:0] lev;
    lev = sch_level_word[sch_slot*4 +: 4];
    if (lev != '0) begin
      r.beacon       = 1'b1;
      r.beacon_level = lev;
      r.power_code   = TX_POWER[lev];
      if (lev == sch_rx_level) begin
        r.receive_flag = 1'b1;
        // A window that is already open is not extended.
        if (!sch_win_open) begin
          sch_win_open = 1'b1;
          sch_win_cnt  = clamp_timer(sch_win_len);
        end
      end
    end
    sch_wait  = clamp_timer(sch_slot_per);
    sch_phase = PH_SLOT;
  endfunction

  function automatic void begin_cycle(inout bpss_result_t r);
    if (!sch_enable || sch_cycle_per < MIN_CYCLE) begin
      r.halted  = 1'b1;
      sch_phase = PH_START;
    end else begin
      sch_slot = '0;
      fire_slot(r);
    end
  endfunction

  function automatic bpss_result_t sched_step(input logic tk);
    bpss_result_t     r;
    longint unsigned  four_slots;
    r = '0;
    if (tk) begin
      if (sch_win_open) begin
        if (sch_win_cnt <= TIMER_ONE) begin
          sch_win_open = 1'b0;
          sch_win_cnt  = '0;
        end else begin
          sch_win_cnt = sch_win_cnt - 1'b1;
        end
      end
      case (sch_phase)
        PH_SLOT: begin
          if (sch_wait > TIMER_ONE) begin
            sch_wait = sch_wait - 1'b1;
          end else if (sch_slot == SLOT_LAST) begin
            four_slots = 4 * longint'(sch_slot_per);
            sch_slot   = '0;
            if (longint'(sch_cycle_per) > four_slots) begin
              sch_wait  = clamp_timer(longint'(sch_cycle_per) - four_slots);
              sch_phase = PH_MAJOR;
            end else begin
              begin_cycle(r);
            end
          end else begin
            sch_slot = sch_slot + 1'b1;
            fire_slot(r);
          end
        end
        PH_MAJOR: begin
          if (sch_wait > TIMER_ONE) begin
            sch_wait = sch_wait - 1'b1;
          end else begin
            begin_cycle(r);
          end
        end
        default: begin
          begin_cycle(r);
        end
      endcase
    end
    r.receiver_on = sch_win_open;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random back-pressure while idling is allowed.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !(idle_on && $urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk) begin
    bpss_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("Result transaction arrived with nothing outstanding");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("beacon", want.beacon, out_ch.beacon);
        check_field("beacon_level", want.beacon_level, out_ch.beacon_level);
        check_field("power_code", want.power_code, out_ch.power_code);
        check_field("receive_flag", want.receive_flag, out_ch.receive_flag);
        check_field("receiver_on", want.receiver_on, out_ch.receiver_on);
        check_field("halted", want.halted, out_ch.halted);
        n_beacons += out_ch.beacon;
        n_flagged += out_ch.receive_flag;
        n_halted  += out_ch.halted;
      end
    end
  end

  // Leaves cfg_we high; the caller lowers it once the batch is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] lw, input logic [LEVEL_W-1:0] rl,
                               input logic [CFG_W-1:0] sp, input logic [CFG_W-1:0] cp,
                               input logic [CFG_W-1:0] wl, input logic en);
    write_reg(CFG_LEVEL_WORD, lw);
    write_reg(CFG_RECEIVE_LEVEL, CFG_W'(rl));
    write_reg(CFG_SLOT_PERIOD, sp);
    write_reg(CFG_CYCLE_PERIOD, cp);
    write_reg(CFG_WINDOW_LENGTH, wl);
    write_reg(CFG_ENABLE, CFG_W'(en));
    cfg_we <= 1'b0;
    sch_level_word = lw;
    sch_rx_level   = rl;
    sch_slot_per   = sp;
    sch_cycle_per  = cp;
    sch_win_len    = wl;
    sch_enable     = en;
    settings_loaded++;
  endtask

  task automatic send_tick(input logic tk);
    if (idle_on && $urandom_range(0, 99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick  <= tk;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(sched_step(tk));
    ticks_sent++;
  endtask

  // Holds the sender back until every outstanding result has been checked.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_halt_checks();
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    wait_idle();
    // Enabled, but a major period below two still halts.
    load_settings(16'h1234, 4'd2, 16'd1, 16'd1, 16'd3, 1'b1);
    repeat (2) send_tick(1'b1);
    wait_idle();
  endtask

  task automatic test_slot_sweep();
    // Levels 1, 7, 15 and a skipped slot; no slot gap and a positive remainder.
    load_settings(16'h0F71, 4'd7, 16'd0, 16'd2, 16'd0, 1'b1);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    repeat (4) send_tick(1'b1);
    wait_idle();
  endtask

  task automatic test_window_reopen();
    // Every slot flagged while a very long window is already open.
    load_settings(16'h5555, 4'd5, 16'd1, 16'd12, 16'hFFFF, 1'b1);
    repeat (8) send_tick(1'b1);
    wait_idle();
  endtask

  function automatic logic [CFG_W-1:0] pick_extreme();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  task automatic run_random_phase(input int n_items);
    int                 mode;
    logic [CFG_W-1:0]   lw;
    logic [LEVEL_W-1:0] rl;
    mode = $urandom_range(0, 9);
    lw   = CFG_W'($urandom);
    rl   = ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom)
                                       : lw[$urandom_range(0, 3)*4 +: 4];
    if (mode == 0) begin
      load_settings(pick_extreme(), rl, pick_extreme(), pick_extreme(), pick_extreme(),
                    1'($urandom));
    end else if (mode == 1) begin
      load_settings(lw, rl, CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 3)),
                    CFG_W'($urandom_range(0, 20)), 1'($urandom));
    end else begin
      load_settings(lw, rl, CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(2, 48)),
                    CFG_W'($urandom_range(0, 24)), 1'b1);
    end
    repeat (n_items) send_tick($urandom_range(0, 99) >= 5);
    wait_idle();
  endtask

  task automatic test_steady_flow();
    idle_on = 1'b0;
    run_random_phase(250);
    idle_on = 1'b1;
  endtask

  task automatic test_random_sweeps();
    int start_count;
    start_count = ticks_sent;
    while (ticks_sent - start_count < RANDOM_ITEMS - 250) begin
      run_random_phase($urandom_range(20, 90));
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.tick  = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    idle_on     = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_halt_checks();
    test_slot_sweep();
    test_window_reopen();
    test_steady_flow();
    test_random_sweeps();
    wait_idle();

    $display("Ran %0d tick transactions across %0d register settings.",
             ticks_sent, settings_loaded);
    $display("Observed %0d beacons, %0d with receive flagged, %0d halted results.",
             n_beacons, n_flagged, n_halted);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
